### hw/rtl/assert_macros.svh
// Assertion macros shared by the ready queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/prq_pkg.sv
// Types, codes and default sizes shared by the ready queue modules.
package prq_pkg;

  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned PriorityBitsDef = 8;

  localparam int unsigned IdW       = 4;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DepthOutW = 5;
  localparam int unsigned OutDataW  = 16;

  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

### hw/rtl/prq_cell.sv
// One queue slot: holds an id and priority and shifts with its neighbours.
module prq_cell import prq_pkg::*; #(
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occupied_i,
  input  logic [IdW-1:0]           new_id_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                     left_keep_i,
  input  logic [IdW-1:0]           left_id_i,
  input  logic [PRIORITY_BITS-1:0] left_prio_i,
  input  logic [IdW-1:0]           right_id_i,
  input  logic [PRIORITY_BITS-1:0] right_prio_i,
  output logic                     keep_o,
  output logic [IdW-1:0]           id_o,
  output logic [PRIORITY_BITS-1:0] prio_o
);

  logic [IdW-1:0]           id_q, id_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;

  // A held entry of equal or higher priority stays in front of a new one.
  assign keep_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    if (ctrl_i.enq && !keep_o) begin
      if (left_keep_i) begin
        id_d   = new_id_i;
        prio_d = new_prio_i;
      end else begin
        id_d   = left_id_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.deq) begin
      id_d   = right_id_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

### hw/rtl/priority_ready_queue_core.sv
// Top level of the priority ready queue: input stage, cell chain and result register.
//
// Each transaction is first captured in the input register. Once the output register is
// free, every cell compares the new priority in parallel and shifts one place along the
// chain while the result is loaded into the output register. A new transaction is not
// accepted while one is held in the input register. A finished result may wait in the
// output register while the next transaction is captured; that transaction is then held
// in the input register until the result is taken. Entries of equal priority leave in
// arrival order, an enqueue into a full queue is dropped and reported, and no clearing
// pass runs after reset.
`include "assert_macros.svh"

module priority_ready_queue_core import prq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef,
  localparam int unsigned InDataW      = ((IdW + PRIORITY_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // proc_id, priority_req, zero padding
  input  logic                s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // out_id, status, depth_now, zero padding
);

  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OutPadW = OutDataW - IdW - StatusW - DepthOutW;

  logic                     busy_q;
  logic                     func_q;
  logic [IdW-1:0]           id_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     m_valid_q;
  logic [OutDataW-1:0]      m_data_q;

  logic                     in_fire;
  logic                     exec;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  status_e                  status;
  logic [IdW-1:0]           out_id;
  logic [31:0]              depth_wide;

  logic [IdW-1:0]           cell_id   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]     keep;
  logic [QUEUE_DEPTH-1:0]   occupied;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec          = busy_q && (!m_valid_q || m_axis_tready);

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status   = StDone;
    out_id   = '0;
    if (func_q == FuncEnq) begin
      if (full) begin
        status = StFull;
      end else begin
        ctrl.enq = exec;
        count_d  = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status = StEmpty;
      end else begin
        ctrl.deq = exec;
        out_id   = cell_id[0];
        count_d  = count_q - 1'b1;
      end
    end
  end

  assign depth_wide = 32'(count_d);

  // The virtual slot ahead of the head always keeps, so the head takes a new entry.
  assign keep[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [IdW-1:0]           left_id, right_id;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;

    assign occupied[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_id   = id_q;
      assign left_prio = prio_q;
    end else begin : g_body
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    prq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[i]),
      .new_id_i    (id_q),
      .new_prio_i  (prio_q),
      .left_keep_i (keep[i]),
      .left_id_i   (left_id),
      .left_prio_i (left_prio),
      .right_id_i  (right_id),
      .right_prio_i(right_prio),
      .keep_o      (keep[i+1]),
      .id_o        (cell_id[i]),
      .prio_o      (cell_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      func_q    <= FuncEnq;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
        func_q <= s_axis_tuser;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q   <= s_axis_tdata[IdW-1:0];
      prio_q <= s_axis_tdata[IdW +: PRIORITY_BITS];
    end
    if (exec) begin
      m_data_q <= {{OutPadW{1'b0}}, depth_wide[DepthOutW-1:0], status, out_id};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `PRQ_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "Entry count exceeds queue depth.")
  `PRQ_ASSERT_NEXT(a_exec_result, exec, m_valid_q && !busy_q, "Executed transaction gave no result.")
  `PRQ_ASSERT_NEXT(a_enq_count, ctrl.enq, count_q == $past(count_q) + 1'b1, "Enqueue count slip.")
  `PRQ_ASSERT_NEXT(a_deq_count, ctrl.deq, count_q == $past(count_q) - 1'b1, "Dequeue count slip.")

  for (genvar k = 0; k + 1 < QUEUE_DEPTH; k++) begin : g_order_chk
    `PRQ_ASSERT(a_sorted, !occupied[k+1] || (cell_prio[k] >= cell_prio[k+1]), "Queue order broken.")
  end

endmodule
